### hw/rtl/dirty_tile_rect_tracker_macros.svh
// Assertion macros for the dirty tile rectangle tracker
`ifndef DIRTY_TILE_RECT_TRACKER_MACROS_SVH
`define DIRTY_TILE_RECT_TRACKER_MACROS_SVH

// same-cycle implication
`define DTR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DTR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/dtr_pkg.sv
// Types and constants shared by the dirty tile rectangle tracker
`timescale 1ns / 1ps
package dtr_pkg;

   localparam int FIELD_W   = 13;
   localparam int LOG2_W    = 3;
   localparam int FUNC_W    = 2;
   localparam int CFG_IDX_W = 3;

   localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_NEXT  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_INVAL = 2'd2;

   localparam logic [CFG_IDX_W-1:0] REG_TILE_X_LOG2  = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_TILE_Y_LOG2  = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH    = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_MAX_HEIGHT   = 3'd5;

   localparam logic [LOG2_W-1:0]  RST_TILE_X_LOG2  = 3'd5;
   localparam logic [LOG2_W-1:0]  RST_TILE_Y_LOG2  = 3'd3;
   localparam logic [FIELD_W-1:0] RST_FRAME_WIDTH  = 13'd2048;
   localparam logic [FIELD_W-1:0] RST_FRAME_HEIGHT = 13'd512;
   localparam logic [FIELD_W-1:0] RST_MAX_WIDTH    = 13'd4096;
   localparam logic [FIELD_W-1:0] RST_MAX_HEIGHT   = 13'd4096;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_NEXT_CHECK,
      ST_ROW_LOAD,
      ST_FIND,
      ST_RUN,
      ST_EXT_CHECK,
      ST_EXT_TEST,
      ST_RESULT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clr_all;
   } mem_req_type;

endpackage

### hw/rtl/dtr_flag_mem.sv
// Dirty flag row memory with per-row valid bits reading as all dirty
`timescale 1ns / 1ps
module dtr_flag_mem #(
   parameter int COLS = 64,
   parameter int ROWS = 64,
   localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  dtr_pkg::mem_req_type req,
   input  logic [AW-1:0]       rd_addr,
   input  logic [AW-1:0]       wr_addr,
   input  logic [COLS-1:0]     wr_data,
   output logic [COLS-1:0]     rd_data
);

   logic [COLS-1:0] mem [ROWS];
   logic [COLS-1:0] data_ff;
   logic [ROWS-1:0] valid_ff;
   logic            rvalid_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (req.rd_en) begin
         data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (req.clr_all) begin
            valid_ff <= '0;
         end else if (req.wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (req.rd_en) begin
            rvalid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rvalid_ff ? data_ff : '1;

endmodule

### hw/rtl/dtr_find_first.sv
// Shared lowest-set-bit finder used for run start and run end searches
`timescale 1ns / 1ps
module dtr_find_first #(
   parameter int W = 65,
   localparam int IW = $clog2(W)
) (
   input  logic [W-1:0]  vec,
   output logic [IW-1:0] idx
);

   logic [W-1:0] lowest;

   assign lowest = vec & (~vec + W'(1));

   always_comb begin
      idx = '0;
      for (int i = 0; i < W; i++) begin
         if (lowest[i]) begin
            idx = idx | IW'(i);
         end
      end
   end

endmodule

### hw/rtl/dirty_tile_rect_tracker.sv
// Dirty tile rectangle tracker: sequencer, configuration and result formatting
// Mark: handled in idle when empty, else MARK_RD, MARK_WR per touched row; invalidate, func 3
// are handled in idle. Next: NEXT_CHECK, ROW_LOAD, FIND per row scanned without a run; the run
// row adds RUN, EXT_CHECK; each extended row EXT_TEST, EXT_CHECK; a failing row test adds
// EXT_TEST, then RESULT. Done: NEXT_CHECK, DONE. Steps share the flag-row memory and finder.
// Result strobe lasts one cycle and busy drops in the next; the receiver cannot stall.
// Synchronous reset: all flags read dirty at once via row valid bits, cursor at top left.
`timescale 1ns / 1ps
`include "dirty_tile_rect_tracker_macros.svh"
module dirty_tile_rect_tracker #(
   parameter int GRID_COLS = 64,
   parameter int GRID_ROWS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [dtr_pkg::FUNC_W-1:0]          req_func,
   input  logic [dtr_pkg::FIELD_W-1:0]         req_mark_left,
   input  logic [dtr_pkg::FIELD_W-1:0]         req_mark_top,
   input  logic [dtr_pkg::FIELD_W-1:0]         req_mark_right,
   input  logic [dtr_pkg::FIELD_W-1:0]         req_mark_bottom,
   output logic                                rsp_strobe,
   output logic                                rsp_rect_valid,
   output logic                                rsp_scan_done,
   output logic [dtr_pkg::FIELD_W-1:0]         rsp_rect_left,
   output logic [dtr_pkg::FIELD_W-1:0]         rsp_rect_top,
   output logic [dtr_pkg::FIELD_W-1:0]         rsp_rect_right,
   output logic [dtr_pkg::FIELD_W-1:0]         rsp_rect_bottom,
   input  logic                                csr_we,
   input  logic [dtr_pkg::CFG_IDX_W-1:0]       csr_index,
   input  logic [dtr_pkg::FIELD_W-1:0]         csr_wdata
);

   localparam int FW  = dtr_pkg::FIELD_W;
   localparam int AW  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int CW  = $clog2(GRID_COLS + 1);
   localparam int RCW = $clog2(GRID_ROWS + 1);
   localparam int TW  = FW + 1;
   localparam int SW  = TW + 1;
   localparam int PXW = (CW + 7 > FW) ? CW + 8 : FW + 1;
   localparam int PYW = (RCW + 7 > FW) ? RCW + 8 : FW + 1;

   function automatic logic [TW-1:0] tiles_of(input logic [FW-1:0] px,
                                              input logic [dtr_pkg::LOG2_W-1:0] lg);
      logic [TW-1:0] s;
      s = {1'b0, px} + ((TW'(1) << lg) - TW'(1));
      return s >> lg;
   endfunction

   // configuration
   logic [dtr_pkg::LOG2_W-1:0] tx_ff, ty_ff;
   logic [FW-1:0]              fw_ff, fh_ff, mw_ff, mh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_ff <= dtr_pkg::RST_TILE_X_LOG2;
         ty_ff <= dtr_pkg::RST_TILE_Y_LOG2;
         fw_ff <= dtr_pkg::RST_FRAME_WIDTH;
         fh_ff <= dtr_pkg::RST_FRAME_HEIGHT;
         mw_ff <= dtr_pkg::RST_MAX_WIDTH;
         mh_ff <= dtr_pkg::RST_MAX_HEIGHT;
      end else if (csr_we) begin
         unique case (csr_index)
            dtr_pkg::REG_TILE_X_LOG2:  tx_ff <= csr_wdata[dtr_pkg::LOG2_W-1:0];
            dtr_pkg::REG_TILE_Y_LOG2:  ty_ff <= csr_wdata[dtr_pkg::LOG2_W-1:0];
            dtr_pkg::REG_FRAME_WIDTH:  fw_ff <= csr_wdata;
            dtr_pkg::REG_FRAME_HEIGHT: fh_ff <= csr_wdata;
            dtr_pkg::REG_MAX_WIDTH:    mw_ff <= csr_wdata;
            dtr_pkg::REG_MAX_HEIGHT:   mh_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // derived grid geometry
   logic [TW-1:0]  tc, tr, maxw_t, maxh_t, maxw, maxh;
   logic [CW-1:0]  cols;
   logic [RCW-1:0] rows;

   always_comb begin
      tc     = tiles_of(fw_ff, tx_ff);
      tr     = tiles_of(fh_ff, ty_ff);
      maxw_t = tiles_of(mw_ff, tx_ff);
      maxh_t = tiles_of(mh_ff, ty_ff);
      cols   = (tc > TW'(GRID_COLS)) ? CW'(GRID_COLS) : tc[CW-1:0];
      rows   = (tr > TW'(GRID_ROWS)) ? RCW'(GRID_ROWS) : tr[RCW-1:0];
      maxw   = (maxw_t == '0) ? TW'(1) : maxw_t;
      maxh   = (maxh_t == '0) ? TW'(1) : maxh_t;
   end

   // sequencer state
   dtr_pkg::state_type state_ff, state_in;
   logic [RCW-1:0]       cursor_row_ff, cursor_row_in;
   logic [CW-1:0]        cursor_col_ff, cursor_col_in;
   logic                 smoothed_ff, smoothed_in;
   logic [GRID_COLS-1:0] cur_ff, cur_in;
   logic [CW-1:0]        sx_ff, sx_in, ex_ff, ex_in;
   logic [RCW-1:0]       er_ff, er_in, endr_ff, endr_in;
   logic [FW-1:0]        mr_ff, mr_in;
   logic [RCW-1:0]       r1_ff, r1_in;
   logic [GRID_COLS-1:0] mk_ff, mk_in;

   dtr_pkg::mem_req_type mreq;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic [GRID_COLS-1:0] wr_data, rd_data;

   logic [GRID_COLS:0]   fvec;
   logic [CW-1:0]        fidx;

   logic                 accept;
   logic [FW-1:0]        c0, r0;
   logic [TW-1:0]        c1_t, r1_t;
   logic [CW-1:0]        c1;
   logic [RCW-1:0]       r1;
   logic [CW-1:0]        endc;
   logic [CW-1:0]        clr_end;
   logic [SW-1:0]        endc_sum, endr_sum;
   logic [RCW-1:0]       endr;
   logic [GRID_COLS-1:0] smooth, clr_mask, run_src;
   logic                 left_set, ext_ok;

   dtr_flag_mem #(.COLS(GRID_COLS), .ROWS(GRID_ROWS)) u_mem (
      .clock   (clock),
      .reset   (reset),
      .req     (mreq),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   dtr_find_first #(.W(GRID_COLS + 1)) u_find (
      .vec (fvec),
      .idx (fidx)
   );

   assign accept = start && !busy;

   // datapath helpers
   always_comb begin
      c0       = req_mark_left >> tx_ff;
      r0       = req_mark_top >> ty_ff;
      c1_t     = tiles_of(req_mark_right, tx_ff);
      r1_t     = tiles_of(req_mark_bottom, ty_ff);
      c1       = (c1_t > TW'(cols)) ? cols : c1_t[CW-1:0];
      r1       = (r1_t > TW'(rows)) ? rows : r1_t[RCW-1:0];
      endc_sum = SW'(sx_ff) + SW'(maxw);
      endc     = (endc_sum > SW'(cols)) ? cols : endc_sum[CW-1:0];
      endr_sum = SW'(cursor_row_ff) + SW'(maxh);
      endr     = (endr_sum > SW'(rows)) ? rows : endr_sum[RCW-1:0];
      run_src  = (state_ff == dtr_pkg::ST_RUN) ? cur_ff : rd_data;
      clr_end  = (state_ff == dtr_pkg::ST_RUN) ? fidx : ex_ff;
      smooth   = rd_data;
      for (int c = 0; c + 2 < GRID_COLS; c += 2) begin
         if (CW'(c + 2) < cols) begin
            smooth[c + 1] = rd_data[c + 1] | (rd_data[c] & rd_data[c + 2]);
         end
      end
      left_set = 1'b0;
      for (int c = 0; c < GRID_COLS; c++) begin
         mk_in[c]    = (FW'(c) >= c0) && (CW'(c) < c1);
         clr_mask[c] = (CW'(c) >= sx_ff) && (CW'(c) < clr_end);
         if ((CW'(c + 1) == sx_ff) && rd_data[c]) begin
            left_set = 1'b1;
         end
         if (state_ff == dtr_pkg::ST_FIND) begin
            fvec[c] = cur_ff[c] && (CW'(c) >= cursor_col_ff) && (CW'(c) < cols);
         end else begin
            fvec[c] = (CW'(c) >= sx_ff) && (!run_src[c] || (CW'(c) >= endc));
         end
      end
      fvec[GRID_COLS] = 1'b1;
      ext_ok = !left_set && (fidx == ex_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dtr_pkg::ST_IDLE: begin
            if (accept && req_func == dtr_pkg::FUNC_NEXT) begin
               state_in = dtr_pkg::ST_NEXT_CHECK;
            end else if (accept && req_func == dtr_pkg::FUNC_MARK && FW'(r1) > r0
                         && c1 > c0[CW-1:0] && c0 < FW'(c1)) begin
               state_in = dtr_pkg::ST_MARK_RD;
            end
         end
         dtr_pkg::ST_MARK_RD: state_in = dtr_pkg::ST_MARK_WR;
         dtr_pkg::ST_MARK_WR: begin
            state_in = (mr_ff + FW'(1) < FW'(r1_ff)) ? dtr_pkg::ST_MARK_RD : dtr_pkg::ST_IDLE;
         end
         dtr_pkg::ST_NEXT_CHECK: begin
            state_in = (cursor_row_ff < rows) ? dtr_pkg::ST_ROW_LOAD : dtr_pkg::ST_DONE;
         end
         dtr_pkg::ST_ROW_LOAD: state_in = dtr_pkg::ST_FIND;
         dtr_pkg::ST_FIND: begin
            state_in = (fidx == CW'(GRID_COLS)) ? dtr_pkg::ST_NEXT_CHECK : dtr_pkg::ST_RUN;
         end
         dtr_pkg::ST_RUN: state_in = dtr_pkg::ST_EXT_CHECK;
         dtr_pkg::ST_EXT_CHECK: begin
            state_in = (er_ff < endr_ff) ? dtr_pkg::ST_EXT_TEST : dtr_pkg::ST_RESULT;
         end
         dtr_pkg::ST_EXT_TEST: begin
            state_in = ext_ok ? dtr_pkg::ST_EXT_CHECK : dtr_pkg::ST_RESULT;
         end
         dtr_pkg::ST_RESULT: state_in = dtr_pkg::ST_IDLE;
         dtr_pkg::ST_DONE:   state_in = dtr_pkg::ST_IDLE;
         default:            state_in = dtr_pkg::ST_IDLE;
      endcase
   end

   // register updates
   always_comb begin
      cursor_row_in = cursor_row_ff;
      cursor_col_in = cursor_col_ff;
      smoothed_in   = smoothed_ff;
      cur_in        = cur_ff;
      sx_in         = sx_ff;
      ex_in         = ex_ff;
      er_in         = er_ff;
      endr_in       = endr_ff;
      mr_in         = mr_ff;
      r1_in         = r1_ff;
      unique case (state_ff)
         dtr_pkg::ST_IDLE: begin
            mr_in = r0;
            r1_in = r1;
         end
         dtr_pkg::ST_MARK_WR: mr_in = mr_ff + FW'(1);
         dtr_pkg::ST_ROW_LOAD: begin
            cur_in      = smoothed_ff ? rd_data : smooth;
            smoothed_in = 1'b1;
         end
         dtr_pkg::ST_FIND: begin
            if (fidx == CW'(GRID_COLS)) begin
               cursor_row_in = cursor_row_ff + RCW'(1);
               cursor_col_in = '0;
               smoothed_in   = 1'b0;
            end
            sx_in = fidx;
         end
         dtr_pkg::ST_RUN: begin
            ex_in   = fidx;
            er_in   = cursor_row_ff + RCW'(1);
            endr_in = endr;
         end
         dtr_pkg::ST_EXT_TEST: begin
            if (ext_ok) begin
               er_in = er_ff + RCW'(1);
            end
         end
         dtr_pkg::ST_RESULT: cursor_col_in = ex_ff;
         dtr_pkg::ST_DONE: begin
            cursor_row_in = '0;
            cursor_col_in = '0;
            smoothed_in   = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dtr_pkg::ST_IDLE;
         cursor_row_ff <= '0;
         cursor_col_ff <= '0;
         smoothed_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_row_ff <= cursor_row_in;
         cursor_col_ff <= cursor_col_in;
         smoothed_ff   <= smoothed_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      sx_ff   <= sx_in;
      ex_ff   <= ex_in;
      er_ff   <= er_in;
      endr_ff <= endr_in;
      mr_ff   <= mr_in;
      r1_ff   <= r1_in;
      if (state_ff == dtr_pkg::ST_IDLE) begin
         mk_ff <= mk_in;
      end
   end

   // outputs
   always_comb begin
      logic [PXW-1:0] lx, rx;
      logic [PYW-1:0] ty, by;
      mreq         = '0;
      rd_addr      = cursor_row_ff[AW-1:0];
      wr_addr      = cursor_row_ff[AW-1:0];
      wr_data      = cur_ff & ~clr_mask;
      busy         = (state_ff != dtr_pkg::ST_IDLE);
      rsp_strobe   = 1'b0;
      rsp_rect_valid  = 1'b0;
      rsp_scan_done   = 1'b0;
      rsp_rect_left   = '0;
      rsp_rect_top    = '0;
      rsp_rect_right  = '0;
      rsp_rect_bottom = '0;
      lx = PXW'(sx_ff) << tx_ff;
      rx = PXW'(ex_ff) << tx_ff;
      ty = PYW'(cursor_row_ff) << ty_ff;
      by = PYW'(er_ff) << ty_ff;
      unique case (state_ff)
         dtr_pkg::ST_IDLE: begin
            mreq.clr_all = accept && (req_func == dtr_pkg::FUNC_INVAL);
         end
         dtr_pkg::ST_MARK_RD: begin
            mreq.rd_en = 1'b1;
            rd_addr    = mr_ff[AW-1:0];
         end
         dtr_pkg::ST_MARK_WR: begin
            mreq.wr_en = 1'b1;
            wr_addr    = mr_ff[AW-1:0];
            wr_data    = rd_data | mk_ff;
         end
         dtr_pkg::ST_NEXT_CHECK: begin
            mreq.rd_en = (cursor_row_ff < rows);
         end
         dtr_pkg::ST_ROW_LOAD: begin
            mreq.wr_en = !smoothed_ff;
            wr_data    = smooth;
         end
         dtr_pkg::ST_RUN: begin
            mreq.wr_en = 1'b1;
         end
         dtr_pkg::ST_EXT_CHECK: begin
            mreq.rd_en = (er_ff < endr_ff);
            rd_addr    = er_ff[AW-1:0];
         end
         dtr_pkg::ST_EXT_TEST: begin
            mreq.wr_en = ext_ok;
            wr_addr    = er_ff[AW-1:0];
            wr_data    = rd_data & ~clr_mask;
         end
         dtr_pkg::ST_RESULT: begin
            rsp_strobe      = 1'b1;
            rsp_rect_valid  = 1'b1;
            rsp_rect_left   = lx[FW-1:0];
            rsp_rect_top    = ty[FW-1:0];
            rsp_rect_right  = (rx > PXW'(fw_ff)) ? fw_ff : rx[FW-1:0];
            rsp_rect_bottom = (by > PYW'(fh_ff)) ? fh_ff : by[FW-1:0];
         end
         dtr_pkg::ST_DONE: begin
            rsp_strobe    = 1'b1;
            rsp_scan_done = 1'b1;
         end
         default: ;
      endcase
   end

   `DTR_ASSERT_IMP(a_rsp_kind, clock, reset, rsp_strobe, rsp_rect_valid != rsp_scan_done, "result must be exactly one of rectangle or done")
   `DTR_ASSERT_IMP(a_rect_order, clock, reset, rsp_strobe && rsp_rect_valid, (rsp_rect_right > rsp_rect_left) && (rsp_rect_bottom > rsp_rect_top), "returned rectangle is empty")
   `DTR_ASSERT_NXT(a_next_busy, clock, reset, start && !busy && req_func == dtr_pkg::FUNC_NEXT, busy, "next transfer did not start the scan")
   `DTR_ASSERT_NXT(a_rsp_idle, clock, reset, rsp_strobe, !busy, "block not idle after result")

endmodule
